// ===== sv/tfck_pkg.sv =====
// Shared types and constants for the top-four candidate keeper.
package tfck_pkg;

  localparam int unsigned POINTS_DEF = 4096;
  localparam int unsigned SLOTS_DEF = 4;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  localparam logic CFG_POINT_LIMIT = 1'b0;
  localparam logic CFG_CURRENT_PHOTO = 1'b1;

  localparam logic [12:0] POINT_LIMIT_RST = 13'd4096;
  localparam logic [15:0] PHOTO_RST = 16'd0;

  typedef enum logic [2:0] {
    OP_INSERT,
    OP_READ,
    OP_WRITE,
    OP_REJECT,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [11:0]        point_index;
    logic [1:0]         slot_select;
    logic [23:0]        u;
    logic [23:0]        v;
    logic [15:0]        photo;
    logic signed [31:0] score;
    logic               lock;
    logic               batch_end;
  } req_t;

  typedef struct packed {
    logic [23:0]        u;
    logic [23:0]        v;
    logic [15:0]        photo;
    logic signed [31:0] score;
    logic               locked;
  } slot_t;

  typedef struct packed {
    logic               accepted;
    logic [1:0]         slot_used;
    logic               out_of_range;
    logic [23:0]        read_u;
    logic [23:0]        read_v;
    logic [15:0]        read_photo;
    logic signed [31:0] read_score;
    logic               read_locked;
    logic [31:0]        accepted_total;
  } res_t;

endpackage

// ===== sv/tfck_front.sv =====
// Front end: configuration registers, command decode and range checks.
module tfck_front #(
  parameter int unsigned POINTS = tfck_pkg::POINTS_DEF,
  parameter int unsigned SLOTS_PER_POINT = tfck_pkg::SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic [1:0]         cmd_i,
  input  logic [11:0]        point_index_i,
  input  logic [1:0]         slot_select_i,
  input  logic [23:0]        u_coord_i,
  input  logic [23:0]        v_coord_i,
  input  logic [15:0]        photo_in_i,
  input  logic signed [31:0] score_in_i,
  input  logic               lock_in_i,
  input  logic               batch_end_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output tfck_pkg::req_t     q_data_o
);
  import tfck_pkg::*;

  logic [12:0] point_limit_q;
  logic [15:0] photo_q;
  logic        pt_ok;
  logic        sel_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_limit_q <= POINT_LIMIT_RST;
      photo_q <= PHOTO_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_POINT_LIMIT:   point_limit_q <= cfg_data_i[12:0];
        CFG_CURRENT_PHOTO: photo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign pt_ok = ({1'b0, point_index_i} < point_limit_q) && (32'(point_index_i) < POINTS);
  assign sel_ok = 32'(slot_select_i) < SLOTS_PER_POINT;

  always_comb begin
    q_data_o.point_index = point_index_i;
    q_data_o.slot_select = slot_select_i;
    q_data_o.u = u_coord_i;
    q_data_o.v = v_coord_i;
    q_data_o.photo = photo_in_i;
    q_data_o.score = score_in_i;
    q_data_o.lock = lock_in_i;
    q_data_o.batch_end = batch_end_i;
    unique case (cmd_i)
      CMD_INSERT: begin
        q_data_o.op = pt_ok ? OP_INSERT : OP_REJECT;
        q_data_o.photo = photo_q;
      end
      CMD_READ:  q_data_o.op = (pt_ok && sel_ok) ? OP_READ : OP_REJECT;
      CMD_WRITE: q_data_o.op = (pt_ok && sel_ok) ? OP_WRITE : OP_REJECT;
      default:   q_data_o.op = OP_NONE;
    endcase
  end

  assign busy_o = q_full_i;
  assign q_push_o = start_i && !q_full_i;

endmodule

// ===== sv/tfck_queue.sv =====
// Small FIFO of decoded requests between front and back end.
module tfck_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tfck_pkg::req_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output tfck_pkg::req_t data_o,
  output logic           empty_o
);
  import tfck_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  req_t            entry_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   cnt_q;

  assign full_o = cnt_q == (PtrW+1)'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== sv/tfck_back.sv =====
// Back end: slot memory read-modify-write, replace-minimum and batch count.
module tfck_back #(
  parameter int unsigned POINTS = tfck_pkg::POINTS_DEF,
  parameter int unsigned SLOTS_PER_POINT = tfck_pkg::SLOTS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  tfck_pkg::req_t q_data_i,
  output logic           q_pop_o,
  output logic           res_valid_o,
  output tfck_pkg::res_t res_o
);
  import tfck_pkg::*;

  localparam int unsigned AddrW = (POINTS > 1) ? $clog2(POINTS) : 1;
  localparam int unsigned SlW = $clog2(SLOTS_PER_POINT);
  localparam logic BK_IDLE = 1'b0;
  localparam logic BK_EXEC = 1'b1;

  typedef slot_t [SLOTS_PER_POINT-1:0] row_t;

  row_t               mem_q [POINTS];
  row_t               rd_row_q;
  row_t               new_row;
  req_t               cur_q;
  res_t               res_q, res_d;
  logic               state_q, state_d;
  logic               valid_q, valid_d;
  logic [31:0]        cnt_q, cnt_d;
  logic [31:0]        pt_head, pt_cur, sel_ext, total;
  logic [AddrW-1:0]   rd_addr, wr_addr;
  logic [SlW-1:0]     sel, best;
  logic signed [31:0] minv;
  logic               exec, any_lock, ins_acc, wr_en;
  slot_t              rd_slot;

  assign pt_head = 32'(q_data_i.point_index);
  assign pt_cur = 32'(cur_q.point_index);
  assign sel_ext = 32'(cur_q.slot_select);
  assign rd_addr = pt_head[AddrW-1:0];
  assign wr_addr = pt_cur[AddrW-1:0];
  assign sel = sel_ext[SlW-1:0];
  assign exec = state_q == BK_EXEC;
  assign q_pop_o = (state_q == BK_IDLE) && !q_empty_i;

  always_comb begin
    unique case (state_q)
      BK_IDLE: state_d = q_empty_i ? BK_IDLE : BK_EXEC;
      BK_EXEC: state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // lowest score, earliest slot on ties; also flags any locked slot
  always_comb begin
    any_lock = 1'b0;
    best = '0;
    minv = $signed(rd_row_q[0].score);
    for (int k = 0; k < SLOTS_PER_POINT; k++) begin
      any_lock = any_lock | rd_row_q[k].locked;
      if ($signed(rd_row_q[k].score) < minv) begin
        minv = $signed(rd_row_q[k].score);
        best = SlW'(k);
      end
    end
  end

  assign ins_acc = exec && (cur_q.op == OP_INSERT) && !any_lock
                   && ($signed(cur_q.score) > minv);
  assign rd_slot = rd_row_q[sel];
  assign total = cnt_q + 32'(ins_acc);

  always_comb begin
    new_row = rd_row_q;
    wr_en = 1'b0;
    if (ins_acc) begin
      new_row[best] = '{u: cur_q.u, v: cur_q.v, photo: cur_q.photo,
                        score: cur_q.score, locked: 1'b0};
      wr_en = 1'b1;
    end else if (exec && (cur_q.op == OP_WRITE)) begin
      new_row[sel] = '{u: cur_q.u, v: cur_q.v, photo: cur_q.photo,
                       score: cur_q.score, locked: cur_q.lock};
      wr_en = 1'b1;
    end
  end

  always_comb begin
    res_d = '0;
    res_d.accepted = ins_acc;
    res_d.slot_used = ins_acc ? 2'(best) : 2'd0;
    res_d.out_of_range = cur_q.op == OP_REJECT;
    if (cur_q.op == OP_READ) begin
      res_d.read_u = rd_slot.u;
      res_d.read_v = rd_slot.v;
      res_d.read_photo = rd_slot.photo;
      res_d.read_score = rd_slot.score;
      res_d.read_locked = rd_slot.locked;
    end
    res_d.accepted_total = total;
    valid_d = exec;
    cnt_d = cnt_q;
    if (exec) begin
      cnt_d = cur_q.batch_end ? 32'd0 : total;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      rd_row_q <= mem_q[rd_addr];
      cur_q <= q_data_i;
    end
    if (wr_en) begin
      mem_q[wr_addr] <= new_row;
    end
    if (exec) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      valid_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      cnt_q <= cnt_d;
    end
  end

  assign res_valid_o = valid_q;
  assign res_o = res_q;

endmodule

// ===== sv/top_four_candidate_keeper_top.sv =====
// Top level of the per-point top-four candidate keeper.
//
// Commands enter on start_i with busy_o low: insert a candidate, read a slot
// or write a slot of one point. Each command gives exactly one result, shown
// for one cycle with done_o high; the receiver always takes it.
// Configuration (point limit, current photo) is written through cfg_we_i,
// cfg_idx_i and cfg_data_i while no command is in flight.
// A two-entry queue parts the decode front end from the back end that owns
// the slot memory, one row of four slots per point.
// The back end reads the point's row when it pops a command and writes it
// back in the next cycle, registering the result as it writes; it pops a
// new command only after that write-back, so the row is read and written
// on a single port.
// busy_o rises when the queue holds two commands.
// Reset clears the configuration to its defaults, the queue, the back end
// state and the batch count; slot contents are undefined until written.
module top_four_candidate_keeper_top #(
  parameter int unsigned POINTS = tfck_pkg::POINTS_DEF,
  parameter int unsigned SLOTS_PER_POINT = tfck_pkg::SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic [1:0]         cmd_i,
  input  logic [11:0]        point_index_i,
  input  logic [1:0]         slot_select_i,
  input  logic [23:0]        u_coord_i,
  input  logic [23:0]        v_coord_i,
  input  logic [15:0]        photo_in_i,
  input  logic signed [31:0] score_in_i,
  input  logic               lock_in_i,
  input  logic               batch_end_i,
  output logic               done_o,
  output logic               accepted_o,
  output logic [1:0]         slot_used_o,
  output logic               out_of_range_o,
  output logic [23:0]        read_u_o,
  output logic [23:0]        read_v_o,
  output logic [15:0]        read_photo_o,
  output logic signed [31:0] read_score_o,
  output logic               read_locked_o,
  output logic [31:0]        accepted_total_o
);
  import tfck_pkg::*;

  logic q_full, q_push, q_pop, q_empty;
  req_t q_in, q_out;
  res_t res;

  tfck_front #(
    .POINTS(POINTS),
    .SLOTS_PER_POINT(SLOTS_PER_POINT)
  ) u_front (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .busy_o(busy_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cmd_i(cmd_i),
    .point_index_i(point_index_i),
    .slot_select_i(slot_select_i),
    .u_coord_i(u_coord_i),
    .v_coord_i(v_coord_i),
    .photo_in_i(photo_in_i),
    .score_in_i(score_in_i),
    .lock_in_i(lock_in_i),
    .batch_end_i(batch_end_i),
    .q_full_i(q_full),
    .q_push_o(q_push),
    .q_data_o(q_in)
  );

  tfck_queue u_queue (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push_i(q_push),
    .data_i(q_in),
    .full_o(q_full),
    .pop_i(q_pop),
    .data_o(q_out),
    .empty_o(q_empty)
  );

  tfck_back #(
    .POINTS(POINTS),
    .SLOTS_PER_POINT(SLOTS_PER_POINT)
  ) u_back (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .q_empty_i(q_empty),
    .q_data_i(q_out),
    .q_pop_o(q_pop),
    .res_valid_o(done_o),
    .res_o(res)
  );

  assign accepted_o = res.accepted;
  assign slot_used_o = res.slot_used;
  assign out_of_range_o = res.out_of_range;
  assign read_u_o = res.read_u;
  assign read_v_o = res.read_v;
  assign read_photo_o = res.read_photo;
  assign read_score_o = res.read_score;
  assign read_locked_o = res.read_locked;
  assign accepted_total_o = res.accepted_total;

endmodule

// ===== tb/tfck_checker.sv =====
// Checker for the top-four candidate keeper: tracks slot state, predicts each result, compares.
`timescale 1ns / 1ps

module tfck_checker #(
  parameter int unsigned POINTS = tfck_pkg::POINTS_DEF,
  parameter int unsigned SLOTS_PER_POINT = tfck_pkg::SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic [1:0]         cmd_i,
  input  logic [11:0]        point_index_i,
  input  logic [1:0]         slot_select_i,
  input  logic [23:0]        u_coord_i,
  input  logic [23:0]        v_coord_i,
  input  logic [15:0]        photo_in_i,
  input  logic signed [31:0] score_in_i,
  input  logic               lock_in_i,
  input  logic               batch_end_i,
  input  logic               done_i,
  input  logic               accepted_i,
  input  logic [1:0]         slot_used_i,
  input  logic               out_of_range_i,
  input  logic [23:0]        read_u_i,
  input  logic [23:0]        read_v_i,
  input  logic [15:0]        read_photo_i,
  input  logic signed [31:0] read_score_i,
  input  logic               read_locked_i,
  input  logic [31:0]        accepted_total_i,
  output int                 errors_o,
  output int                 pending_o
);
  import tfck_pkg::*;

  slot_t       slot_mem [POINTS * SLOTS_PER_POINT];
  logic [12:0] point_limit_q;
  logic [15:0] photo_q;
  logic [31:0] batch_count;
  res_t        expected_results [$];

  // Applies the command on the input ports to the slot store, returns its result.
  function automatic res_t process_command();
    res_t               r;
    logic               pt_ok;
    logic               locked;
    int unsigned        base;
    int unsigned        best;
    logic signed [31:0] min_score;
    logic signed [31:0] s;
    r = '0;
    pt_ok = (point_index_i < point_limit_q) && (point_index_i < POINTS);
    base = point_index_i * SLOTS_PER_POINT;
    case (cmd_i)
      CMD_INSERT: begin
        if (!pt_ok) begin
          r.out_of_range = 1'b1;
        end else begin
          locked = 1'b0;
          best = 0;
          min_score = slot_mem[base].score;
          for (int k = 0; k < SLOTS_PER_POINT; k++) begin
            s = slot_mem[base + k].score;
            if (slot_mem[base + k].locked) locked = 1'b1;
            if (s < min_score) begin
              min_score = s;
              best = k;
            end
          end
          if (!locked && score_in_i > min_score) begin
            slot_mem[base + best] = '{u: u_coord_i, v: v_coord_i, photo: photo_q,
                                      score: score_in_i, locked: 1'b0};
            batch_count = batch_count + 1;
            r.accepted = 1'b1;
            r.slot_used = best[1:0];
          end
        end
      end
      CMD_READ, CMD_WRITE: begin
        if (!pt_ok || slot_select_i >= SLOTS_PER_POINT) begin
          r.out_of_range = 1'b1;
        end else if (cmd_i == CMD_READ) begin
          r.read_u = slot_mem[base + slot_select_i].u;
          r.read_v = slot_mem[base + slot_select_i].v;
          r.read_photo = slot_mem[base + slot_select_i].photo;
          r.read_score = slot_mem[base + slot_select_i].score;
          r.read_locked = slot_mem[base + slot_select_i].locked;
        end else begin
          slot_mem[base + slot_select_i] = '{u: u_coord_i, v: v_coord_i, photo: photo_in_i,
                                             score: score_in_i, locked: lock_in_i};
        end
      end
      default: begin
      end
    endcase
    r.accepted_total = batch_count;
    if (batch_end_i) batch_count = '0;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      if (errors_o < 10) begin
        $display("%0t mismatch %s: expected %h got %h", $realtime, name, exp_v, act_v);
      end
      errors_o = errors_o + 1;
    end
  endtask

  task automatic check_result();
    res_t e;
    if (expected_results.size() == 0) begin
      if (errors_o < 10) $display("%0t result with no command outstanding", $realtime);
      errors_o = errors_o + 1;
    end else begin
      e = expected_results.pop_front();
      check_field("accepted", 32'(e.accepted), 32'(accepted_i));
      check_field("slot_used", 32'(e.slot_used), 32'(slot_used_i));
      check_field("out_of_range", 32'(e.out_of_range), 32'(out_of_range_i));
      check_field("read_u", 32'(e.read_u), 32'(read_u_i));
      check_field("read_v", 32'(e.read_v), 32'(read_v_i));
      check_field("read_photo", 32'(e.read_photo), 32'(read_photo_i));
      check_field("read_score", e.read_score, read_score_i);
      check_field("read_locked", 32'(e.read_locked), 32'(read_locked_i));
      check_field("accepted_total", e.accepted_total, accepted_total_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_results.delete();
      batch_count = '0;
      point_limit_q = POINT_LIMIT_RST;
      photo_q = PHOTO_RST;
      pending_o = 0;
      errors_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_POINT_LIMIT) point_limit_q = cfg_data_i[12:0];
        else photo_q = cfg_data_i;
      end
      if (done_i) check_result();
      if (start_i && !busy_i) expected_results.push_back(process_command());
      pending_o = expected_results.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Testbench top for the top-four candidate keeper: stimulus, configuration phases, verdict.
`timescale 1ns / 1ps

module testbench;
  import tfck_pkg::*;

  localparam logic [1:0]  CMD_NOP = 2'd3;
  localparam int unsigned ENTRIES = POINTS_DEF * SLOTS_DEF;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned ITEMS_PER_PHASE = 385;
  localparam logic [31:0] SCORE_MIN = 32'h8000_0000;
  localparam logic [31:0] SCORE_MAX = 32'h7FFF_FFFF;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               cfg_we;
  logic               cfg_idx;
  logic [15:0]        cfg_data;
  logic [1:0]         cmd;
  logic [11:0]        point_index;
  logic [1:0]         slot_select;
  logic [23:0]        u_coord;
  logic [23:0]        v_coord;
  logic [15:0]        photo_in;
  logic signed [31:0] score_in;
  logic               lock_in;
  logic               batch_end;
  logic               done;
  logic               accepted;
  logic [1:0]         slot_used;
  logic               out_of_range;
  logic [23:0]        read_u;
  logic [23:0]        read_v;
  logic [15:0]        read_photo;
  logic signed [31:0] read_score;
  logic               read_locked;
  logic [31:0]        accepted_total;
  int                 errors;
  int                 pending;

  int unsigned        cycles = 0;
  int unsigned        burst_left = 0;
  bit                 written_map [ENTRIES];
  logic [12:0]        limit_now = POINT_LIMIT_RST;
  logic [11:0]        hot_points [6];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  top_four_candidate_keeper_top i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_o           (busy),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .cmd_i            (cmd),
    .point_index_i    (point_index),
    .slot_select_i    (slot_select),
    .u_coord_i        (u_coord),
    .v_coord_i        (v_coord),
    .photo_in_i       (photo_in),
    .score_in_i       (score_in),
    .lock_in_i        (lock_in),
    .batch_end_i      (batch_end),
    .done_o           (done),
    .accepted_o       (accepted),
    .slot_used_o      (slot_used),
    .out_of_range_o   (out_of_range),
    .read_u_o         (read_u),
    .read_v_o         (read_v),
    .read_photo_o     (read_photo),
    .read_score_o     (read_score),
    .read_locked_o    (read_locked),
    .accepted_total_o (accepted_total)
  );

  tfck_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_i           (busy),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .cmd_i            (cmd),
    .point_index_i    (point_index),
    .slot_select_i    (slot_select),
    .u_coord_i        (u_coord),
    .v_coord_i        (v_coord),
    .photo_in_i       (photo_in),
    .score_in_i       (score_in),
    .lock_in_i        (lock_in),
    .batch_end_i      (batch_end),
    .done_i           (done),
    .accepted_i       (accepted),
    .slot_used_i      (slot_used),
    .out_of_range_i   (out_of_range),
    .read_u_i         (read_u),
    .read_v_i         (read_v),
    .read_photo_i     (read_photo),
    .read_score_i     (read_score),
    .read_locked_i    (read_locked),
    .accepted_total_i (accepted_total),
    .errors_o         (errors),
    .pending_o        (pending)
  );

  function automatic int unsigned idle_gap();
    int unsigned pick;
    if (burst_left != 0) begin
      burst_left = burst_left - 1;
      return 0;
    end
    pick = $urandom_range(99);
    if (pick < 2) begin
      burst_left = $urandom_range(40, 20);
      return 0;
    end
    if (pick < 47) return 0;
    if (pick < 82) return $urandom_range(3, 1);
    if (pick < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Mix of tie-prone small values, extremes and full-range scores.
  function automatic logic [31:0] random_score();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) return 32'($signed($urandom_range(32)) - 16);
    if (pick < 40) begin
      case ($urandom_range(3))
        0: return SCORE_MIN;
        1: return SCORE_MAX;
        2: return 32'h0;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  // Start stays high across back-to-back transfers; it drops only for a gap.
  task automatic issue(input logic [1:0] c, input logic [11:0] pt, input logic [1:0] sel,
                       input logic [23:0] u, input logic [23:0] v, input logic [15:0] ph,
                       input logic [31:0] sc, input logic lk, input logic be);
    int unsigned gap;
    cmd = c;
    point_index = pt;
    slot_select = sel;
    u_coord = u;
    v_coord = v;
    photo_in = ph;
    score_in = sc;
    lock_in = lk;
    batch_end = be;
    start = 1'b1;
    if (c == CMD_WRITE && pt < limit_now) written_map[pt * SLOTS_DEF + sel] = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    gap = idle_gap();
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [15:0] data);
    drain();
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_data = 16'($urandom);
    if (idx == CFG_POINT_LIMIT) begin
      limit_now = data[12:0];
      hot_points[0] = '0;
      hot_points[1] = 12'(limit_now - 1);
      for (int k = 2; k < 6; k++) hot_points[k] = 12'($urandom_range(limit_now - 1));
    end
  endtask

  // Inserts and reads that would touch never-written slots turn into fills.
  task automatic random_item();
    logic [1:0]  c;
    logic [11:0] pt;
    logic [1:0]  sel;
    logic        lk;
    int unsigned pick;
    int unsigned base;
    pick = $urandom_range(99);
    if (pick < 70) pt = hot_points[$urandom_range(5)];
    else if (pick < 88) pt = 12'($urandom_range(limit_now - 1));
    else pt = 12'($urandom);
    sel = 2'($urandom);
    pick = $urandom_range(99);
    if (pick < 55) c = CMD_INSERT;
    else if (pick < 75) c = CMD_READ;
    else if (pick < 96) c = CMD_WRITE;
    else c = CMD_NOP;
    base = pt * SLOTS_DEF;
    if (pt < limit_now && c == CMD_INSERT) begin
      for (int k = SLOTS_DEF - 1; k >= 0; k--) begin
        if (!written_map[base + k]) begin
          c = CMD_WRITE;
          sel = 2'(k);
        end
      end
    end
    if (pt < limit_now && c == CMD_READ && !written_map[base + sel]) c = CMD_WRITE;
    lk = (c == CMD_WRITE) ? ($urandom_range(99) < 8) : 1'($urandom);
    issue(c, pt, sel, 24'($urandom), 24'($urandom), 16'($urandom), random_score(), lk,
          $urandom_range(99) < 6);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = 1'b0;
    cfg_data = '0;
    cmd = CMD_INSERT;
    point_index = '0;
    slot_select = '0;
    u_coord = '0;
    v_coord = '0;
    photo_in = '0;
    score_in = '0;
    lock_in = 1'b0;
    batch_end = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    write_cfg(CFG_CURRENT_PHOTO, 16'hFFFF);
    write_cfg(CFG_POINT_LIMIT, 16'd4096);
    // min search, ties, strict compare, extremes
    issue(CMD_WRITE, 12'd0, 2'd0, 24'hFFFFFF, 24'h0, 16'hFFFF, 32'd10, 1'b0, 1'b0);
    issue(CMD_WRITE, 12'd0, 2'd1, 24'h0, 24'hFFFFFF, 16'h0, 32'd3, 1'b0, 1'b0);
    issue(CMD_WRITE, 12'd0, 2'd2, 24'h123456, 24'hABCDEF, 16'h5A5A, 32'd3, 1'b0, 1'b0);
    issue(CMD_WRITE, 12'd0, 2'd3, 24'h800000, 24'h7FFFFF, 16'hA5A5, SCORE_MAX, 1'b0, 1'b0);
    issue(CMD_READ, 12'd0, 2'd0, 24'($urandom), 24'($urandom), 16'($urandom), $urandom,
          1'b1, 1'b0);
    issue(CMD_READ, 12'd0, 2'd3, 24'($urandom), 24'($urandom), 16'($urandom), $urandom,
          1'b0, 1'b0);
    issue(CMD_INSERT, 12'd0, 2'd3, 24'h111111, 24'h222222, 16'h0, 32'd3, 1'b0, 1'b0);
    issue(CMD_INSERT, 12'd0, 2'd0, 24'h333333, 24'h444444, 16'h0, 32'd4, 1'b0, 1'b0);
    issue(CMD_INSERT, 12'd0, 2'd0, 24'h555555, 24'h666666, 16'h0, 32'd4, 1'b0, 1'b0);
    issue(CMD_INSERT, 12'd0, 2'd0, 24'hFFFFFF, 24'hFFFFFF, 16'h0, SCORE_MIN, 1'b0, 1'b0);
    issue(CMD_READ, 12'd0, 2'd1, 24'($urandom), 24'($urandom), 16'($urandom), $urandom,
          1'b0, 1'b0);
    // locked point blocks inserts until the lock is cleared
    issue(CMD_WRITE, 12'd4095, 2'd0, 24'h1, 24'h2, 16'h3, SCORE_MIN, 1'b0, 1'b0);
    issue(CMD_WRITE, 12'd4095, 2'd1, 24'h4, 24'h5, 16'h6, SCORE_MIN, 1'b0, 1'b0);
    issue(CMD_WRITE, 12'd4095, 2'd2, 24'h7, 24'h8, 16'h9, SCORE_MIN, 1'b0, 1'b0);
    issue(CMD_WRITE, 12'd4095, 2'd3, 24'hA, 24'hB, 16'hC, SCORE_MIN, 1'b1, 1'b0);
    issue(CMD_INSERT, 12'd4095, 2'd0, 24'hFFFFFF, 24'h0, 16'h0, SCORE_MAX, 1'b0, 1'b0);
    issue(CMD_READ, 12'd4095, 2'd3, 24'($urandom), 24'($urandom), 16'($urandom), $urandom,
          1'b0, 1'b0);
    issue(CMD_WRITE, 12'd4095, 2'd3, 24'hA, 24'hB, 16'hC, SCORE_MIN, 1'b0, 1'b0);
    issue(CMD_INSERT, 12'd4095, 2'd2, 24'hFFFFFF, 24'h0, 16'h0, SCORE_MAX, 1'b0, 1'b0);
    issue(CMD_NOP, 12'd4095, 2'd3, 24'($urandom), 24'($urandom), 16'($urandom), $urandom,
          1'b1, 1'b1);
    repeat (ITEMS_PER_PHASE) random_item();

    write_cfg(CFG_POINT_LIMIT, 16'd1);
    write_cfg(CFG_CURRENT_PHOTO, 16'h0000);
    issue(CMD_INSERT, 12'd1, 2'd0, 24'($urandom), 24'($urandom), 16'($urandom), SCORE_MAX,
          1'b0, 1'b0);
    issue(CMD_READ, 12'd4095, 2'd0, 24'($urandom), 24'($urandom), 16'($urandom), $urandom,
          1'b0, 1'b0);
    issue(CMD_WRITE, 12'd4095, 2'd1, 24'($urandom), 24'($urandom), 16'($urandom), $urandom,
          1'b1, 1'b0);
    issue(CMD_INSERT, 12'd0, 2'd0, 24'($urandom), 24'($urandom), 16'($urandom), SCORE_MAX,
          1'b0, 1'b1);
    repeat (ITEMS_PER_PHASE) random_item();

    write_cfg(CFG_POINT_LIMIT, 16'($urandom_range(4095, 2)));
    write_cfg(CFG_CURRENT_PHOTO, 16'($urandom));
    repeat (ITEMS_PER_PHASE) random_item();

    write_cfg(CFG_POINT_LIMIT, 16'd4096);
    write_cfg(CFG_CURRENT_PHOTO, 16'($urandom));
    repeat (ITEMS_PER_PHASE) random_item();

    drain();
    repeat (10) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tfck_pkg.sv
sv/tfck_front.sv
sv/tfck_queue.sv
sv/tfck_back.sv
sv/top_four_candidate_keeper_top.sv
tb/tfck_checker.sv
tb/testbench.sv
